// File: src/mfps_pkg.sv
`timescale 1ns / 1ps
package mfps_pkg;

  localparam int MAX_COLS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CNT_W    = $clog2(MAX_COLS + 1);
  localparam int COLS_W   = 11;
  localparam int VALUE_W  = 16;
  localparam int COST_W   = 32;
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [PADDR_W-1:0] ADDR_COLUMNS = PADDR_W'(0);
  localparam logic [COLS_W-1:0]  COLUMNS_RST  = COLS_W'(MAX_COLS);

  localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
  localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

  // one beat as it travels down the chain; data holds the cell value until
  // the owning column has turned it into a cost
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              row_end;
    logic              first_row;
    logic              use_left;
    logic              use_right;
    logic [COL_W-1:0]  col;
    logic [COST_W-1:0] data;
  } item_t;

endpackage

// File: src/mfps_regs.sv
`timescale 1ns / 1ps
module mfps_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfps_pkg::PADDR_W-1:0]  paddr,
  input  logic [mfps_pkg::PDATA_W-1:0]  pwdata,
  output logic [mfps_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [mfps_pkg::CNT_W-1:0]    row_len_o
);

  logic [mfps_pkg::COLS_W-1:0] columns_q;
  logic                        columns_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= mfps_pkg::COLUMNS_RST;
    end else if (psel && penable && pwrite && (paddr == mfps_pkg::ADDR_COLUMNS)) begin
      columns_q <= pwdata[mfps_pkg::COLS_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      mfps_pkg::ADDR_COLUMNS: prdata = mfps_pkg::PDATA_W'(columns_q);
      default:                prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // zero or anything above the chain length means a full-width row
  assign columns_ok = (columns_q != '0) && (32'(columns_q) <= mfps_pkg::MAX_COLS);
  assign row_len_o  = columns_ok ? mfps_pkg::CNT_W'(columns_q)
                                 : mfps_pkg::CNT_W'(mfps_pkg::MAX_COLS);

endmodule

// File: src/mfps_cell.sv
`timescale 1ns / 1ps
module mfps_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic [mfps_pkg::COL_W-1:0]       idx_i,
  input  mfps_pkg::item_t                  item_i,
  input  logic signed [mfps_pkg::COST_W-1:0] left_prev_i,
  input  logic signed [mfps_pkg::COST_W-1:0] right_cost_i,
  output mfps_pkg::item_t                  item_o,
  output logic signed [mfps_pkg::COST_W-1:0] cost_o,
  output logic signed [mfps_pkg::COST_W-1:0] cost_fwd_o,
  output logic signed [mfps_pkg::COST_W-1:0] prev_o
);

  mfps_pkg::item_t                       item_q, item_d;
  logic signed [mfps_pkg::COST_W-1:0]    cost_q, prev_q;
  logic                                  hit;
  logic signed [mfps_pkg::VALUE_W-1:0]   value;
  logic signed [mfps_pkg::COST_W-1:0]    best;
  logic signed [mfps_pkg::COST_W:0]      sum;
  logic signed [mfps_pkg::COST_W-1:0]    cost_new;

  assign hit   = item_i.valid && (item_i.col == idx_i);
  assign value = item_i.data[mfps_pkg::VALUE_W-1:0];

  always_comb begin
    best = cost_q;
    if (item_i.use_left && (left_prev_i < best)) begin
      best = left_prev_i;
    end
    if (item_i.use_right && (right_cost_i < best)) begin
      best = right_cost_i;
    end
    sum = {best[mfps_pkg::COST_W-1], best}
        + {{(mfps_pkg::COST_W + 1 - mfps_pkg::VALUE_W){value[mfps_pkg::VALUE_W-1]}}, value};
    if (item_i.first_row) begin
      cost_new = {{(mfps_pkg::COST_W - mfps_pkg::VALUE_W){value[mfps_pkg::VALUE_W-1]}}, value};
    end else if (sum[mfps_pkg::COST_W] != sum[mfps_pkg::COST_W-1]) begin
      cost_new = sum[mfps_pkg::COST_W] ? mfps_pkg::COST_MIN : mfps_pkg::COST_MAX;
    end else begin
      cost_new = sum[mfps_pkg::COST_W-1:0];
    end
    item_d = item_i;
    if (hit) begin
      item_d.data = cost_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (adv_i) begin
      item_q <= item_d;
    end
  end

  // prev keeps the cost from the row before, the left neighbor of the next column
  always_ff @(posedge clk_i) begin
    if (adv_i && hit) begin
      cost_q <= cost_new;
      prev_q <= cost_q;
    end
  end

  assign item_o     = item_q;
  assign cost_o     = cost_q;
  // cost as it stands after this edge, for a neighbor costed in the same cycle
  assign cost_fwd_o = hit ? cost_new : cost_q;
  assign prev_o     = prev_q;

endmodule

// File: src/mfps_result.sv
`timescale 1ns / 1ps
module mfps_result (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  mfps_pkg::item_t                 item_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic signed [mfps_pkg::COST_W-1:0] path_sum_o
);

  logic signed [mfps_pkg::COST_W-1:0] row_min_q, row_min_d;
  logic signed [mfps_pkg::COST_W-1:0] sum_q;
  logic signed [mfps_pkg::COST_W-1:0] run_min;
  logic                               out_valid_q;
  logic                               take;

  assign take    = adv_i && item_i.valid;
  assign run_min = ($signed(item_i.data) < row_min_q) ? $signed(item_i.data) : row_min_q;

  always_comb begin
    row_min_d = row_min_q;
    if (take) begin
      row_min_d = (item_i.last || item_i.row_end) ? mfps_pkg::COST_MAX : run_min;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_min_q   <= mfps_pkg::COST_MAX;
      out_valid_q <= 1'b0;
    end else begin
      row_min_q <= row_min_d;
      if (take && item_i.last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last) begin
      sum_q <= run_min;
    end
  end

  assign out_valid_o = out_valid_q;
  assign path_sum_o  = sum_q;

endmodule

// File: src/min_falling_path_sum_unit.sv
`timescale 1ns / 1ps
// throughput: one cell beat per cycle while the chain advances; each beat walks the
// whole chain of column cells, is costed in its own column's cell, and a last beat's
// result is registered in the result stage; the chain length sets the latency
// the chain pauses only while a result waits and the next last beat reaches the end
// reset: columns back to 1024, stream at first row column 0, chain empty, no result
// the stored row costs are not cleared and hold nothing useful until written
module min_falling_path_sum_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mfps_pkg::PADDR_W-1:0]        paddr,
  input  logic [mfps_pkg::PDATA_W-1:0]        pwdata,
  output logic [mfps_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [mfps_pkg::VALUE_W-1:0] cell_value_i,
  input  logic                                last_cell_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mfps_pkg::COST_W-1:0]  path_sum_o
);

  localparam logic [mfps_pkg::COL_W-1:0] COL_LAST = mfps_pkg::COL_W'(mfps_pkg::MAX_COLS - 1);

  logic [mfps_pkg::CNT_W-1:0]  row_len;
  logic [mfps_pkg::COL_W-1:0]  col_q;
  logic                        first_q;
  logic                        adv;
  logic                        accept;
  logic                        row_end;
  mfps_pkg::item_t             entry;
  mfps_pkg::item_t             chain [mfps_pkg::MAX_COLS];
  logic signed [mfps_pkg::COST_W-1:0] cost [mfps_pkg::MAX_COLS];
  logic signed [mfps_pkg::COST_W-1:0] fwd [mfps_pkg::MAX_COLS];
  logic signed [mfps_pkg::COST_W-1:0] prev [mfps_pkg::MAX_COLS];
  mfps_pkg::item_t             exit_item;

  mfps_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .row_len_o (row_len)
  );

  assign exit_item  = chain[mfps_pkg::MAX_COLS-1];
  // only a new result colliding with one still held stops the chain
  assign adv        = !(out_valid_o && out_stall_i && exit_item.valid && exit_item.last);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  assign row_end = ((mfps_pkg::CNT_W'(col_q) + mfps_pkg::CNT_W'(1)) >= row_len);

  always_comb begin
    entry.valid     = accept;
    entry.last      = last_cell_i;
    entry.row_end   = row_end;
    entry.first_row = first_q;
    entry.use_left  = (col_q != '0);
    entry.use_right = !row_end && (col_q != COL_LAST);
    entry.col       = col_q;
    entry.data      = {{(mfps_pkg::COST_W - mfps_pkg::VALUE_W){cell_value_i[mfps_pkg::VALUE_W-1]}},
                       cell_value_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else if (accept) begin
      if (last_cell_i) begin
        col_q   <= '0;
        first_q <= 1'b1;
      end else if (row_end) begin
        col_q   <= '0;
        first_q <= 1'b0;
      end else begin
        col_q <= col_q + mfps_pkg::COL_W'(1);
      end
    end
  end

  for (genvar k = 0; k < mfps_pkg::MAX_COLS; k++) begin : g_cell
    mfps_pkg::item_t                    item_in;
    logic signed [mfps_pkg::COST_W-1:0] left_prev;
    logic signed [mfps_pkg::COST_W-1:0] right_cost;

    if (k == 0) begin : g_head
      assign item_in   = entry;
      assign left_prev = '0;
    end else begin : g_body
      assign item_in   = chain[k-1];
      assign left_prev = prev[k-1];
    end

    if (k == mfps_pkg::MAX_COLS - 1) begin : g_tail
      assign right_cost = '0;
    end else if (k == 0) begin : g_lead
      // on a two-column row the right neighbor is costed in the same cycle
      assign right_cost = fwd[k+1];
    end else begin : g_inner
      assign right_cost = cost[k+1];
    end

    mfps_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .adv_i        (adv),
      .idx_i        (mfps_pkg::COL_W'(k)),
      .item_i       (item_in),
      .left_prev_i  (left_prev),
      .right_cost_i (right_cost),
      .item_o       (chain[k]),
      .cost_o       (cost[k]),
      .cost_fwd_o   (fwd[k]),
      .prev_o       (prev[k])
    );
  end

  mfps_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (exit_item),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .path_sum_o  (path_sum_o)
  );

  a_stall_only_on_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && exit_item.valid && exit_item.last))
    else $error("input stalled without a blocked result");

  a_last_restarts_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_cell_i) |=> (first_q && (col_q == '0)))
    else $error("stream did not restart after last beat");

  a_last_exit_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && exit_item.valid && exit_item.last) |=> out_valid_o)
    else $error("last beat left the chain without a result");

  a_result_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(exit_item.valid && exit_item.last && adv))
    else $error("result raised without a last beat");

endmodule
